// ===== rtl/bfsp_pkg.sv =====
// bfsp_pkg: shared widths, opcodes, register indexes and types of the
// single-source shortest path block
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package bfsp_pkg;

    // default sizes of the graph storage
    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 1024;
    localparam int WEIGHT_BITS_DEF  = 16;

    // fixed field widths of the channels
    localparam int OPCODE_W    = 2;
    localparam int VERTEX_W    = 6;
    localparam int VCOUNT_W    = 7;
    localparam int WEIGHT_IN_W = 16;
    localparam int WEIGHT_EXT_W = 32;
    localparam int DIST_OUT_W  = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;

    // item opcodes
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RUN   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT  = 1'd1;

    // configuration reset values
    localparam logic [VERTEX_W-1:0] SOURCE_RESET = 6'd0;
    localparam logic [VCOUNT_W-1:0] COUNT_RESET  = 7'd64;

    // edge table command from the sequencer
    typedef struct packed {
        logic                           clear;
        logic                           add;
        logic [VERTEX_W-1:0]            tail;
        logic [VERTEX_W-1:0]            head;
        logic signed [WEIGHT_EXT_W-1:0] weight;
    } edge_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bfsp_if.sv =====
// bfsp_if: valid/ready channel interfaces for items, results and
// configuration writes
// depends on bfsp_pkg
`timescale 1ns / 1ps
`default_nettype none

// input item channel
interface bfsp_item_if import bfsp_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [OPCODE_W-1:0]           opcode;
    logic [VERTEX_W-1:0]           edge_source;
    logic [VERTEX_W-1:0]           edge_dest;
    logic signed [WEIGHT_IN_W-1:0] edge_weight;

    modport source (output valid, opcode, edge_source, edge_dest, edge_weight,
                    input ready);
    modport sink   (input valid, opcode, edge_source, edge_dest, edge_weight,
                    output ready);
endinterface

// result channel
interface bfsp_result_if import bfsp_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [VERTEX_W-1:0]          vertex_index;
    logic signed [DIST_OUT_W-1:0] distance;
    logic                         reachable;
    logic [VERTEX_W-1:0]          predecessor;
    logic                         negative_cycle;
    logic                         last;

    modport source (output valid, vertex_index, distance, reachable, predecessor,
                    negative_cycle, last, input ready);
    modport sink   (input valid, vertex_index, distance, reachable, predecessor,
                    negative_cycle, last, output ready);
endinterface

// configuration write channel
interface bfsp_cfg_if import bfsp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bfsp_edge_store.sv =====
// bfsp_edge_store: edge table memory with fill count, one write port and
// one registered read port
// depends on bfsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module bfsp_edge_store import bfsp_pkg::*; #(
    parameter  int MAX_EDGES   = MAX_EDGES_DEF,
    parameter  int WEIGHT_BITS = WEIGHT_BITS_DEF,
    localparam int EIDX_W      = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    localparam int ECNT_W      = $clog2(MAX_EDGES + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire edge_cmd_t                     edge_cmd,
    input  wire logic [EIDX_W-1:0]             rd_addr,
    output logic [ECNT_W-1:0]                  edge_total,
    output logic [VERTEX_W-1:0]                rd_tail,
    output logic [VERTEX_W-1:0]                rd_head,
    output logic signed [WEIGHT_BITS-1:0]      rd_weight
);

    localparam int ENTRY_W = 2 * VERTEX_W + WEIGHT_BITS;

    logic [ENTRY_W-1:0] edge_mem [0:MAX_EDGES-1];
    logic [ENTRY_W-1:0] rd_entry_reg;
    logic [ECNT_W-1:0]  total_reg;
    logic [ECNT_W-1:0]  total_next;
    logic               wr_en;

    // append only while there is room
    assign wr_en = edge_cmd.add && (total_reg < ECNT_W'(MAX_EDGES));

    // fill count
    always_comb
    begin
        total_next = total_reg;
        if (edge_cmd.clear)
        begin
            total_next = '0;
        end
        else if (wr_en)
        begin
            total_next = total_reg + ECNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    // edge memory, weight wraps to the stored width
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            edge_mem[total_reg[EIDX_W-1:0]] <=
                {edge_cmd.tail, edge_cmd.head, edge_cmd.weight[WEIGHT_BITS-1:0]};
        end
        rd_entry_reg <= edge_mem[rd_addr];
    end

    assign edge_total = total_reg;
    assign rd_tail    = rd_entry_reg[ENTRY_W-1 -: VERTEX_W];
    assign rd_head    = rd_entry_reg[WEIGHT_BITS + VERTEX_W - 1 -: VERTEX_W];
    assign rd_weight  = $signed(rd_entry_reg[WEIGHT_BITS-1:0]);

    // the fill count never passes the table size
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= ECNT_W'(MAX_EDGES))
        else $error("edge count above table size");

    // a clear empties the table on the next cycle
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        edge_cmd.clear |=> total_reg == '0)
        else $error("edge table not cleared");

    // a dropped add leaves the count at full
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        edge_cmd.add && !edge_cmd.clear && total_reg == ECNT_W'(MAX_EDGES)
        |=> total_reg == ECNT_W'(MAX_EDGES))
        else $error("add into full table changed count");

endmodule

`default_nettype wire

// ===== rtl/bfsp_relax_unit.sv =====
// bfsp_relax_unit: shared relaxation datapath, one add and one signed
// compare per use
// depends on bfsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module bfsp_relax_unit import bfsp_pkg::*; #(
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
    parameter int DIST_W      = WEIGHT_BITS_DEF + 8
) (
    input  wire logic signed [DIST_W-1:0]      tail_dist,
    input  wire logic signed [WEIGHT_BITS-1:0] weight,
    input  wire logic signed [DIST_W-1:0]      head_dist,
    input  wire logic                          head_ok,
    output logic signed [DIST_W-1:0]           cand,
    output logic                               improve
);

    // candidate distance through this edge
    assign cand = tail_dist + DIST_W'(weight);

    // strict improvement or first reach of the head
    assign improve = !head_ok || (cand < head_dist);

endmodule

`default_nettype wire

// ===== rtl/bfsp_core.sv =====
// bfsp_core: run sequencer, distance and predecessor memories, result
// register
// depends on bfsp_pkg, bfsp_if, bfsp_relax_unit
`timescale 1ns / 1ps
`default_nettype none

module bfsp_core import bfsp_pkg::*; #(
    parameter  int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter  int MAX_EDGES    = MAX_EDGES_DEF,
    parameter  int WEIGHT_BITS  = WEIGHT_BITS_DEF,
    localparam int EIDX_W       = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    localparam int ECNT_W       = $clog2(MAX_EDGES + 1)
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    bfsp_item_if.sink                     item,
    bfsp_result_if.source                 result,
    input  wire logic [VERTEX_W-1:0]      source_vertex,
    input  wire logic [VCOUNT_W-1:0]      vertex_count,
    output edge_cmd_t                     edge_cmd,
    output logic [EIDX_W-1:0]             edge_rd_addr,
    input  wire logic [ECNT_W-1:0]        edge_total,
    input  wire logic [VERTEX_W-1:0]      edge_tail,
    input  wire logic [VERTEX_W-1:0]      edge_head,
    input  wire logic signed [WEIGHT_BITS-1:0] edge_weight
);

    localparam int VIDX_W = $clog2(MAX_VERTICES);
    localparam int DIST_W = WEIGHT_BITS + VIDX_W + 2;
    localparam int SAT_W  = (DIST_W > DIST_OUT_W) ? DIST_W : DIST_OUT_W;
    localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sh7FFF_FFFF);
    localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-(64'sh8000_0000));

    // sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_INIT     = 4'd1;
    localparam logic [3:0] ST_PASS_SEL = 4'd2;
    localparam logic [3:0] ST_EDGE_RD  = 4'd3;
    localparam logic [3:0] ST_EDGE_CHK = 4'd4;
    localparam logic [3:0] ST_RELAX    = 4'd5;
    localparam logic [3:0] ST_PASS_END = 4'd6;
    localparam logic [3:0] ST_COPY_RD  = 4'd7;
    localparam logic [3:0] ST_COPY_WR  = 4'd8;
    localparam logic [3:0] ST_EMIT_RD  = 4'd9;
    localparam logic [3:0] ST_EMIT_LD  = 4'd10;

    logic [3:0]              state_reg, state_next;
    logic [VCOUNT_W-1:0]     n_reg, n_next;
    logic [VCOUNT_W-1:0]     pass_reg, pass_next;
    logic [ECNT_W-1:0]       eidx_reg, eidx_next;
    logic [VIDX_W-1:0]       vtx_reg, vtx_next;
    logic                    check_reg, check_next;
    logic                    changed_reg, changed_next;
    logic                    cycle_reg, cycle_next;
    logic [MAX_VERTICES-1:0] prev_ok_reg, prev_ok_next;
    logic [MAX_VERTICES-1:0] cur_ok_reg, cur_ok_next;
    logic [MAX_VERTICES-1:0] pred_ok_reg, pred_ok_next;

    logic                        out_valid_reg, out_valid_next;
    logic [VERTEX_W-1:0]         out_index_reg;
    logic signed [DIST_OUT_W-1:0] out_dist_reg;
    logic                        out_reach_reg;
    logic [VERTEX_W-1:0]         out_pred_reg;
    logic                        out_cycle_reg;
    logic                        out_last_reg;

    // distance and predecessor memories
    logic signed [DIST_W-1:0] prev_mem [0:MAX_VERTICES-1];
    logic signed [DIST_W-1:0] cur_mem  [0:MAX_VERTICES-1];
    logic [VERTEX_W-1:0]      pred_mem [0:MAX_VERTICES-1];
    logic signed [DIST_W-1:0] prev_rd_reg;
    logic signed [DIST_W-1:0] cur_rd_reg;
    logic [VERTEX_W-1:0]      pred_rd_reg;

    logic [VIDX_W-1:0]        prev_raddr, cur_raddr;
    logic                     prev_we, cur_we, pred_we;
    logic [VIDX_W-1:0]        prev_waddr, cur_waddr;
    logic signed [DIST_W-1:0] prev_wdata, cur_wdata;

    logic                     accept;
    logic [VIDX_W-1:0]        tail_idx, head_idx, src_idx;
    logic                     tail_in, head_in, src_in, vtx_is_last;
    logic signed [DIST_W-1:0] cand;
    logic                     improve;
    logic                     load_out;
    logic signed [SAT_W-1:0]  dist_wide, dist_sat;

    assign accept      = item.valid && item.ready;
    assign item.ready  = (state_reg == ST_IDLE);
    assign tail_idx    = edge_tail[VIDX_W-1:0];
    assign head_idx    = edge_head[VIDX_W-1:0];
    assign src_idx     = source_vertex[VIDX_W-1:0];
    assign tail_in     = VCOUNT_W'(edge_tail) < n_reg;
    assign head_in     = VCOUNT_W'(edge_head) < n_reg;
    assign src_in      = VCOUNT_W'(source_vertex) < n_reg;
    assign vtx_is_last = VCOUNT_W'(vtx_reg) == (n_reg - VCOUNT_W'(1));
    assign edge_rd_addr = eidx_reg[EIDX_W-1:0];

    // edge table commands straight from the accepted beat
    always_comb
    begin
        edge_cmd.clear  = accept && (item.opcode == OP_CLEAR);
        edge_cmd.add    = accept && (item.opcode == OP_ADD);
        edge_cmd.tail   = item.edge_source;
        edge_cmd.head   = item.edge_dest;
        edge_cmd.weight = WEIGHT_EXT_W'(item.edge_weight);
    end

    // shared relaxation unit
    bfsp_relax_unit #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .DIST_W      (DIST_W)
    ) u_relax (
        .tail_dist (prev_rd_reg),
        .weight    (edge_weight),
        .head_dist (cur_rd_reg),
        .head_ok   (cur_ok_reg[head_idx]),
        .cand      (cand),
        .improve   (improve)
    );

    // memory read addresses
    assign prev_raddr = (state_reg == ST_EDGE_CHK) ? tail_idx : vtx_reg;
    assign cur_raddr  = (state_reg == ST_EDGE_CHK) ? head_idx : vtx_reg;

    // memory write controls
    always_comb
    begin
        prev_we    = 1'b0;
        prev_waddr = vtx_reg;
        prev_wdata = cur_rd_reg;
        cur_we     = 1'b0;
        cur_waddr  = head_idx;
        cur_wdata  = cand;
        pred_we    = (state_reg == ST_RELAX) && improve && !check_reg;
        if (state_reg == ST_INIT)
        begin
            prev_we    = src_in;
            prev_waddr = src_idx;
            prev_wdata = '0;
            cur_we     = src_in;
            cur_waddr  = src_idx;
            cur_wdata  = '0;
        end
        else if (state_reg == ST_COPY_WR)
        begin
            prev_we = 1'b1;
        end
        else if (state_reg == ST_RELAX)
        begin
            cur_we = improve;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        prev_rd_reg <= prev_mem[prev_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[cur_waddr] <= cur_wdata;
        end
        cur_rd_reg <= cur_mem[cur_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pred_we)
        begin
            pred_mem[head_idx] <= edge_tail;
        end
        pred_rd_reg <= pred_mem[vtx_reg];
    end

    // saturate the exact distance to the output range
    assign dist_wide = SAT_W'(prev_rd_reg);
    always_comb
    begin
        priority if (dist_wide > SAT_MAX)
        begin
            dist_sat = SAT_MAX;
        end
        else if (dist_wide < SAT_MIN)
        begin
            dist_sat = SAT_MIN;
        end
        else
        begin
            dist_sat = dist_wide;
        end
    end

    assign load_out = (state_reg == ST_EMIT_LD) && (!out_valid_reg || result.ready);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        pass_next    = pass_reg;
        eidx_next    = eidx_reg;
        vtx_next     = vtx_reg;
        check_next   = check_reg;
        changed_next = changed_reg;
        cycle_next   = cycle_reg;
        prev_ok_next = prev_ok_reg;
        cur_ok_next  = cur_ok_reg;
        pred_ok_next = pred_ok_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.opcode == OP_RUN))
                begin
                    priority if (vertex_count == '0)
                    begin
                        n_next = VCOUNT_W'(1);
                    end
                    else if (vertex_count > VCOUNT_W'(MAX_VERTICES))
                    begin
                        n_next = VCOUNT_W'(MAX_VERTICES);
                    end
                    else
                    begin
                        n_next = vertex_count;
                    end
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                prev_ok_next = '0;
                cur_ok_next  = '0;
                pred_ok_next = '0;
                if (src_in)
                begin
                    prev_ok_next[src_idx] = 1'b1;
                    cur_ok_next[src_idx]  = 1'b1;
                end
                pass_next  = '0;
                state_next = ST_PASS_SEL;
            end
            ST_PASS_SEL:
            begin
                check_next   = !((pass_reg + VCOUNT_W'(1)) < n_reg);
                eidx_next    = '0;
                changed_next = 1'b0;
                state_next   = ST_EDGE_RD;
            end
            ST_EDGE_RD:
            begin
                if (eidx_reg == edge_total)
                begin
                    state_next = ST_PASS_END;
                end
                else
                begin
                    state_next = ST_EDGE_CHK;
                end
            end
            ST_EDGE_CHK:
            begin
                if (tail_in && head_in && prev_ok_reg[tail_idx])
                begin
                    state_next = ST_RELAX;
                end
                else
                begin
                    eidx_next  = eidx_reg + ECNT_W'(1);
                    state_next = ST_EDGE_RD;
                end
            end
            ST_RELAX:
            begin
                if (improve)
                begin
                    cur_ok_next[head_idx] = 1'b1;
                    changed_next          = 1'b1;
                    if (!check_reg)
                    begin
                        pred_ok_next[head_idx] = 1'b1;
                    end
                end
                eidx_next  = eidx_reg + ECNT_W'(1);
                state_next = ST_EDGE_RD;
            end
            ST_PASS_END:
            begin
                if (check_reg)
                begin
                    cycle_next = changed_reg;
                    vtx_next   = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    pass_next = pass_reg + VCOUNT_W'(1);
                    if (changed_reg)
                    begin
                        prev_ok_next = cur_ok_reg;
                        vtx_next     = '0;
                        state_next   = ST_COPY_RD;
                    end
                    else
                    begin
                        // settled early: go straight to the cycle check
                        check_next   = 1'b1;
                        eidx_next    = '0;
                        changed_next = 1'b0;
                        state_next   = ST_EDGE_RD;
                    end
                end
            end
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                if (vtx_is_last)
                begin
                    state_next = ST_PASS_SEL;
                end
                else
                begin
                    vtx_next   = vtx_reg + VIDX_W'(1);
                    state_next = ST_COPY_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (load_out)
                begin
                    if (vtx_is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        vtx_next   = vtx_reg + VIDX_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= VCOUNT_W'(MAX_VERTICES);
            pass_reg      <= '0;
            eidx_reg      <= '0;
            vtx_reg       <= '0;
            check_reg     <= 1'b0;
            changed_reg   <= 1'b0;
            cycle_reg     <= 1'b0;
            prev_ok_reg   <= '0;
            cur_ok_reg    <= '0;
            pred_ok_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            pass_reg      <= pass_next;
            eidx_reg      <= eidx_next;
            vtx_reg       <= vtx_next;
            check_reg     <= check_next;
            changed_reg   <= changed_next;
            cycle_reg     <= cycle_next;
            prev_ok_reg   <= prev_ok_next;
            cur_ok_reg    <= cur_ok_next;
            pred_ok_reg   <= pred_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_index_reg <= VERTEX_W'(vtx_reg);
            out_reach_reg <= prev_ok_reg[vtx_reg];
            out_dist_reg  <= prev_ok_reg[vtx_reg] ? DIST_OUT_W'(dist_sat) : '0;
            out_pred_reg  <= (prev_ok_reg[vtx_reg] && pred_ok_reg[vtx_reg])
                             ? pred_rd_reg : '0;
            out_cycle_reg <= cycle_reg;
            out_last_reg  <= vtx_is_last;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.vertex_index   = out_index_reg;
    assign result.distance       = out_dist_reg;
    assign result.reachable      = out_reach_reg;
    assign result.predecessor    = out_pred_reg;
    assign result.negative_cycle = out_cycle_reg;
    assign result.last           = out_last_reg;

    // a run beat starts the init step
    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.opcode == OP_RUN) |=> state_reg == ST_INIT)
        else $error("run beat did not start a run");

    // relaxation only touches vertices in range
    a_relax_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RELAX |-> tail_in && head_in)
        else $error("relaxation on out of range edge");

    // a committing pass never runs past n-1 passes
    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RELAX && !check_reg |-> (pass_reg + VCOUNT_W'(1)) < n_reg)
        else $error("too many committing passes");

    // a held result is not overwritten
    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT_LD && out_valid_reg && !result.ready
        |=> state_reg == ST_EMIT_LD && out_valid_reg)
        else $error("result register overwritten");

endmodule

`default_nettype wire

// ===== rtl/single_source_shortest_path.sv =====
// single_source_shortest_path: top level, configuration registers and the
// edge table beside the run sequencer
// depends on bfsp_pkg, bfsp_if, bfsp_edge_store, bfsp_core
//
// channel  dir  payload                                          accepted when
// item     in   opcode, edge_source, edge_dest, edge_weight      valid & ready
// result   out  vertex_index, distance, reachable, predecessor,  valid & ready
//               negative_cycle, last
// cfg      in   index (0 source_vertex, 1 vertex_count), data    valid & ready
//
// clear and add beats are taken only while idle; cfg is always ready.
// a run does at most n-1 committing passes over the E stored edges, n being
// the vertex count, then one checking pass, then emits one result per
// vertex; each edge goes through the single relaxation unit, and each
// committing pass that changes a distance is followed by a copy sweep.
// reset clears the edge count and all reach flags; item ready is low
// during a run, and a stalled result holds the sequencer in place.
`timescale 1ns / 1ps
`default_nettype none

module single_source_shortest_path import bfsp_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bfsp_item_if.sink     item,
    bfsp_result_if.source result,
    bfsp_cfg_if.sink      cfg
);

    localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECNT_W = $clog2(MAX_EDGES + 1);

    logic [VERTEX_W-1:0]          source_reg;
    logic [VCOUNT_W-1:0]          count_reg;
    edge_cmd_t                    edge_cmd;
    logic [EIDX_W-1:0]            edge_rd_addr;
    logic [ECNT_W-1:0]            edge_total;
    logic [VERTEX_W-1:0]          edge_tail;
    logic [VERTEX_W-1:0]          edge_head;
    logic signed [WEIGHT_BITS-1:0] edge_weight;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_reg <= SOURCE_RESET;
            count_reg  <= COUNT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_SOURCE: source_reg <= cfg.data[VERTEX_W-1:0];
                CFG_COUNT:  count_reg  <= cfg.data[VCOUNT_W-1:0];
                default:    source_reg <= source_reg;
            endcase
        end
    end

    // edge table
    bfsp_edge_store #(
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_edges (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_cmd   (edge_cmd),
        .rd_addr    (edge_rd_addr),
        .edge_total (edge_total),
        .rd_tail    (edge_tail),
        .rd_head    (edge_head),
        .rd_weight  (edge_weight)
    );

    // run sequencer
    bfsp_core #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .result        (result),
        .source_vertex (source_reg),
        .vertex_count  (count_reg),
        .edge_cmd      (edge_cmd),
        .edge_rd_addr  (edge_rd_addr),
        .edge_total    (edge_total),
        .edge_tail     (edge_tail),
        .edge_head     (edge_head),
        .edge_weight   (edge_weight)
    );

endmodule

`default_nettype wire

// ===== test/shortest_path_checker.sv =====
// shortest_path_checker: watches the item, configuration and result channels,
// predicts the per-vertex results of every run and compares them beat by beat
// depends on bfsp_pkg and bfsp_if
`timescale 1ns / 1ps

module shortest_path_checker import bfsp_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    bfsp_item_if   item,
    bfsp_result_if result,
    bfsp_cfg_if    cfg,
    output int     failures,
    output int     outstanding
);

    typedef struct packed {
        logic [VERTEX_W-1:0]          vertex;
        logic signed [DIST_OUT_W-1:0] dist_val;
        logic                         reach;
        logic [VERTEX_W-1:0]          pred;
        logic                         cycle_flag;
        logic                         last_flag;
    } vertex_result_t;

    // edge store and configuration copy
    logic [VERTEX_W-1:0]          tail_mem [MAX_EDGES_DEF];
    logic [VERTEX_W-1:0]          head_mem [MAX_EDGES_DEF];
    logic signed [WEIGHT_IN_W-1:0] len_mem [MAX_EDGES_DEF];
    int                           edge_cnt = 0;
    logic [VERTEX_W-1:0]          source_reg = SOURCE_RESET;
    logic [VCOUNT_W-1:0]          count_reg = COUNT_RESET;

    // distances, reach flags and predecessors of the committed passes
    longint                       path_len [MAX_VERTICES_DEF];
    bit                           path_ok [MAX_VERTICES_DEF];
    logic [VERTEX_W-1:0]          path_from [MAX_VERTICES_DEF];

    vertex_result_t               expected_vertices [$];
    int                           mismatches = 0;
    int                           waiting = 0;

    assign failures    = mismatches;
    assign outstanding = waiting;

    // one relaxation pass over the stored edges, true if any distance dropped or a vertex was first reached
    function automatic bit relax_round(int n, bit commit);
        longint cur_len [MAX_VERTICES_DEF];
        bit     cur_ok [MAX_VERTICES_DEF];
        bit     changed;
        longint cand;
        int     t;
        int     h;
        changed = 1'b0;
        cur_len = path_len;
        cur_ok  = path_ok;
        for (int e = 0; e < edge_cnt; e++) begin
            t = tail_mem[e];
            h = head_mem[e];
            if (t >= n || h >= n)
                continue;
            if (!path_ok[t])
                continue;
            cand = path_len[t] + longint'(len_mem[e]);
            if (!cur_ok[h] || cand < cur_len[h]) begin
                cur_len[h] = cand;
                cur_ok[h]  = 1'b1;
                if (commit)
                    path_from[h] = VERTEX_W'(t);
                changed = 1'b1;
            end
        end
        if (commit) begin
            path_len = cur_len;
            path_ok  = cur_ok;
        end
        return changed;
    endfunction

    // full run: up to n-1 passes until stable, one probing pass, then one result per vertex
    function automatic void predict_run();
        int             n;
        bit             cyc;
        longint         d;
        vertex_result_t r;
        n = count_reg;
        if (n < 1)
            n = 1;
        if (n > MAX_VERTICES_DEF)
            n = MAX_VERTICES_DEF;
        for (int v = 0; v < MAX_VERTICES_DEF; v++) begin
            path_len[v]  = 0;
            path_ok[v]   = 1'b0;
            path_from[v] = '0;
        end
        if (source_reg < n)
            path_ok[source_reg] = 1'b1;
        for (int p = 0; p + 1 < n; p++) begin
            if (!relax_round(n, 1'b1))
                break;
        end
        cyc = relax_round(n, 1'b0);
        for (int v = 0; v < n; v++) begin
            d = path_len[v];
            if (d > longint'(32'sh7fffffff))
                d = 32'sh7fffffff;
            if (d < -longint'(32'sh7fffffff) - 1)
                d = -longint'(32'sh7fffffff) - 1;
            r.vertex     = VERTEX_W'(v);
            r.dist_val   = path_ok[v] ? DIST_OUT_W'(d) : '0;
            r.reach      = path_ok[v];
            r.pred       = path_ok[v] ? path_from[v] : '0;
            r.cycle_flag = cyc;
            r.last_flag  = (v == n - 1);
            expected_vertices.push_back(r);
        end
    endfunction

    function automatic void compare_field(string name, logic signed [31:0] want,
                                          logic signed [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // follow every accepted beat on the three channels
    always @(posedge clk)
    begin : watch
        vertex_result_t want;
        if (rst_n) begin
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == CFG_SOURCE)
                    source_reg = cfg.data[VERTEX_W-1:0];
                else if (cfg.index == CFG_COUNT)
                    count_reg = cfg.data;
            end
            if (item.valid && item.ready) begin
                case (item.opcode)
                    OP_CLEAR: edge_cnt = 0;
                    OP_ADD:
                    begin
                        // a full table drops the edge
                        if (edge_cnt < MAX_EDGES_DEF) begin
                            tail_mem[edge_cnt] = item.edge_source;
                            head_mem[edge_cnt] = item.edge_dest;
                            len_mem[edge_cnt]  = item.edge_weight;
                            edge_cnt++;
                        end
                    end
                    OP_RUN: predict_run();
                    default: ;
                endcase
            end
            if (result.valid && result.ready) begin
                if (expected_vertices.size() == 0) begin
                    $error("result beat for vertex %0d with no expectation waiting",
                           result.vertex_index);
                    mismatches++;
                end
                else begin
                    want = expected_vertices.pop_front();
                    compare_field("vertex_index", want.vertex, result.vertex_index);
                    compare_field("distance", want.dist_val, result.distance);
                    compare_field("reachable", want.reach, result.reachable);
                    compare_field("predecessor", want.pred, result.predecessor);
                    compare_field("negative_cycle", want.cycle_flag, result.negative_cycle);
                    compare_field("last", want.last_flag, result.last);
                end
            end
            waiting = expected_vertices.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// tb_top: stimulus and verdict for single_source_shortest_path; loads edge
// tables, changes configuration between runs and leaves checking to the checker
// depends on bfsp_pkg, bfsp_if, single_source_shortest_path, shortest_path_checker
`timescale 1ns / 1ps

module tb_top;
    import bfsp_pkg::*;

    localparam int CLOCK_LIMIT   = 30000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 250;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   steady = 1'b0;
    int   cycle_count = 0;
    int   items_sent = 0;
    int   random_start;
    int   span = 64;
    int   table_fill = 0;
    int   phase;
    int   flavor;
    int   burst;
    int   cfg_pick;
    int   vcount;
    int   vsource;
    int   mismatch_total;
    int   pending_vertices;

    bfsp_item_if   item_ch ();
    bfsp_result_if result_ch ();
    bfsp_cfg_if    cfg_ch ();

    single_source_shortest_path uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    shortest_path_checker path_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .failures    (mismatch_total),
        .outstanding (pending_vertices)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CLOCK_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        result_ch.ready <= steady || ($urandom_range(0, 99) >= 22);
    end

    // present one item beat and hold it until accepted; returns on a falling edge
    task automatic send_item(logic [OPCODE_W-1:0] op, int tail, int head, int weight);
        if (!steady) begin
            while ($urandom_range(0, 99) < 22) begin
                item_ch.valid <= 1'b0;
                @(negedge clk);
            end
        end
        item_ch.valid       <= 1'b1;
        item_ch.opcode      <= op;
        item_ch.edge_source <= tail[VERTEX_W-1:0];
        item_ch.edge_dest   <= head[VERTEX_W-1:0];
        item_ch.edge_weight <= weight[WEIGHT_IN_W-1:0];
        do @(posedge clk); while (!item_ch.ready);
        @(negedge clk);
        if (op != OP_NONE)
            items_sent++;
    endtask

    // one register write, after which valid is dropped before returning
    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
        if (index == CFG_COUNT)
            span = (data == 0) ? 1 : (data > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(data);
    endtask

    // drain all expected results, then let the block go idle
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (pending_vertices != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic int pick_weight(int style);
        case (style)
            0: return $urandom_range(0, 200);
            1: return int'($urandom_range(0, 300)) - 100;
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return -32768;
                    1: return 32767;
                    default: return $urandom_range(0, 65535);
                endcase
            end
        endcase
    endfunction

    // mostly in range, now and then any vertex
    function automatic int pick_vertex();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 63);
        return $urandom_range(0, span - 1);
    endfunction

    initial
    begin
        item_ch.valid       = 1'b0;
        item_ch.opcode      = OP_CLEAR;
        item_ch.edge_source = '0;
        item_ch.edge_dest   = '0;
        item_ch.edge_weight = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_SOURCE;
        cfg_ch.data         = '0;
        result_ch.ready     = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty table at reset settings: only the source is reachable
        send_item(OP_RUN, 0, 0, 0);
        settle();
        write_reg(CFG_COUNT, 7'd5);

        // improvement through a detour, weight extremes, out-of-range edges
        send_item(OP_ADD, 0, 1, 4);
        send_item(OP_ADD, 0, 2, 1);
        send_item(OP_ADD, 2, 1, 2);
        send_item(OP_ADD, 1, 3, -32768);
        send_item(OP_ADD, 3, 4, 32767);
        send_item(OP_ADD, 0, 63, 7);
        send_item(OP_ADD, 63, 0, 7);
        send_item(OP_NONE, 63, 63, -1);
        send_item(OP_RUN, 0, 0, 0);
        settle();

        // vertex count zero acts as one
        write_reg(CFG_COUNT, 7'd0);
        send_item(OP_RUN, 0, 0, 0);
        settle();

        // source beyond the vertex count
        write_reg(CFG_COUNT, 7'd5);
        write_reg(CFG_SOURCE, 7'd9);
        send_item(OP_RUN, 0, 0, 0);

        // negative cycle between vertices 1 and 2
        send_item(OP_CLEAR, 0, 0, 0);
        send_item(OP_ADD, 0, 1, 1);
        send_item(OP_ADD, 1, 2, -3);
        send_item(OP_ADD, 2, 1, 1);
        settle();
        write_reg(CFG_SOURCE, 7'd0);
        send_item(OP_RUN, 0, 0, 0);
        settle();

        // count above the maximum, source at its top with the spare bit set
        write_reg(CFG_COUNT, 7'd127);
        write_reg(CFG_SOURCE, 7'h7f);
        send_item(OP_ADD, 63, 0, -5);
        send_item(OP_RUN, 0, 0, 0);

        // random graphs: mostly clear, load, run with random content
        random_start = items_sent;
        phase = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            steady = (phase >= 5 && phase < 10);
            if (phase == 0 || $urandom_range(0, 3) == 0) begin
                settle();
                cfg_pick = $urandom_range(0, 99);
                if (cfg_pick < 70)
                    vcount = $urandom_range(2, 12);
                else if (cfg_pick < 85)
                    vcount = $urandom_range(13, 64);
                else if (cfg_pick < 92)
                    vcount = $urandom_range(0, 1);
                else
                    vcount = $urandom_range(65, 127);
                write_reg(CFG_COUNT, vcount[CFG_DATA_W-1:0]);
                if ($urandom_range(0, 6) == 0)
                    vsource = $urandom_range(0, 127);
                else
                    vsource = $urandom_range(0, span - 1);
                write_reg(CFG_SOURCE, vsource[CFG_DATA_W-1:0]);
            end
            if (table_fill > 48 || $urandom_range(0, 4) != 0) begin
                send_item(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 65535));
                table_fill = 0;
            end
            flavor = $urandom_range(0, 9);
            flavor = (flavor < 6) ? 0 : (flavor < 9) ? 1 : 2;
            burst = $urandom_range(0, 14);
            for (int k = 0; k < burst; k++) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 65535));
                send_item(OP_ADD, pick_vertex(), pick_vertex(), pick_weight(flavor));
                table_fill++;
            end
            send_item(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 65535));
            if ($urandom_range(0, 4) == 0)
                send_item(OP_RUN, 0, 0, 0);
            phase++;
        end
        steady = 1'b0;

        settle();
        if (mismatch_total == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bfsp_pkg.sv
rtl/bfsp_if.sv
rtl/bfsp_edge_store.sv
rtl/bfsp_relax_unit.sv
rtl/bfsp_core.sv
rtl/single_source_shortest_path.sv
test/shortest_path_checker.sv
test/tb_top.sv
